FILE: design/kmer_saturating_counter_unit_defines.svh
// Assertion macros shared by the checker of the k-mer counter.
// No dependencies; each macro expects clk and arst_n in the using scope.
`ifndef KMER_SATURATING_COUNTER_UNIT_DEFINES_SVH
`define KMER_SATURATING_COUNTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define KMER_SC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("k-mer counter assertion failed");

// Next-cycle implication, disabled while in reset.
`define KMER_SC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("k-mer counter assertion failed");

`endif

FILE: design/kmer_sc_pkg.sv
// Package for the k-mer counter: widths, codes, response word type and base decoder.
// No dependencies; used by every other file of the block except the assertion macro header.
package kmer_sc_pkg;

	localparam int unsigned KMER_MAX_K_DEF = 8;
	localparam int unsigned KMER_LEN_W     = 4;
	localparam logic [KMER_LEN_W-1:0] KMER_LEN_RST = 4'd8;
	localparam int unsigned IDX_PORT_W     = 16;
	localparam int unsigned COUNT_W        = 8;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hff;
	localparam int unsigned APB_ADDR_W     = 3;
	localparam int unsigned APB_DATA_W     = 32;
	localparam int unsigned RSP_FIFO_DEPTH = 4;

	typedef enum logic {
		REQ_ADD  = 1'b0,
		REQ_READ = 1'b1
	} req_kind_t;

	typedef enum logic [0:0] {
		REG_KMER_LENGTH = 1'b0
	} reg_index_t;

	typedef struct packed {
		logic       ok;
		logic [1:0] code;
	} base_code_t;

	typedef struct packed {
		logic                  kmer_valid;
		logic [IDX_PORT_W-1:0] kmer_index;
		logic [COUNT_W-1:0]    kmer_count;
	} kmer_rsp_t;

	// Map a sequence character to its 2-bit nucleotide code.
	function automatic base_code_t decode_base(input logic [7:0] ch);
		base_code_t r;
		r.ok   = 1'b1;
		r.code = 2'd0;
		unique case (ch)
			8'h41, 8'h61: r.code = 2'd0;                 // A a
			8'h43, 8'h63: r.code = 2'd1;                 // C c
			8'h47, 8'h67: r.code = 2'd2;                 // G g
			8'h54, 8'h74, 8'h55, 8'h75: r.code = 2'd3;   // T t U u
			default: r.ok = 1'b0;
		endcase
		return r;
	endfunction

endpackage

FILE: design/kmer_sc_if.sv
// Request and response channel interfaces of the k-mer counter.
// Depends on kmer_sc_pkg for field widths.
interface kmer_sc_req_if import kmer_sc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  req_type;
	logic [7:0]            base_char;
	logic                  seq_start;
	logic [IDX_PORT_W-1:0] query_index;

	modport source (output valid, req_type, base_char, seq_start, query_index, input ready);
	modport sink   (input valid, req_type, base_char, seq_start, query_index, output ready);
endinterface

interface kmer_sc_rsp_if import kmer_sc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  kmer_valid;
	logic [IDX_PORT_W-1:0] kmer_index;
	logic [COUNT_W-1:0]    kmer_count;

	modport source (output valid, kmer_valid, kmer_index, kmer_count, input ready);
	modport sink   (input valid, kmer_valid, kmer_index, kmer_count, output ready);
endinterface

FILE: design/kmer_saturating_counter_unit.sv
// Top level of the k-mer counter: window tracking, counter pipeline, response queue, APB.
// Depends on kmer_sc_pkg, kmer_sc_if, kmer_sc_count_ram and kmer_sc_rsp_fifo.
//
// Counts nucleotide k-mers in a direct table of 4^MAX_K saturating 8-bit counters. An add
// word shifts its base (A, C, G, T/U in either case) into a rolling window of k bases; a
// sequence-start flag clears the window first and any other character clears it outright.
// Once k bases are held, the counter of the packed k-mer (first base in the high bits) is
// incremented, stopping at 255, and the new value is returned; otherwise an all-zero result
// is returned. A read word returns the counter at query_index, masked to the table size,
// and leaves the window alone. Every request word yields exactly one response word, in order.
// Throughput is one word per cycle: the counter RAM is read when a word is taken and written
// back in the cycle after, and a one-entry forward covers a word that hits the counter just
// being written. A response is offered once its word has passed stage 1 and a four-word
// response queue, which lets requests keep flowing while responses are stalled; apart from
// the reset sweep, request ready drops only when the queue plus the word in flight would
// overfill it. After reset all 4^MAX_K entries (65536 at MAX_K = 8) are cleared one entry
// per cycle, and no request is taken during the sweep; kmer_length (register 0, byte
// address 0, reset 8) takes effect from the next request word taken, so write it only while
// no word is in flight. A kmer_length of 0 acts as 1 and one above MAX_K acts as MAX_K.
module kmer_saturating_counter_unit import kmer_sc_pkg::*; #(
	parameter int unsigned MAX_K = KMER_MAX_K_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	kmer_sc_req_if.sink           req,
	kmer_sc_rsp_if.source         rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);
	localparam int unsigned IDX_W  = 2 * MAX_K;
	localparam int unsigned HELD_W = $clog2(MAX_K + 1);
	localparam int unsigned CNT_W  = $clog2(RSP_FIFO_DEPTH + 1);

	// Configuration
	logic [KMER_LEN_W-1:0] kmer_len_q;
	logic                  cfg_wr;
	logic                  cfg_sel_len;

	// Window state
	logic [IDX_W-1:0]  win_q;
	logic [HELD_W-1:0] held_q;
	logic [HELD_W-1:0] k_eff;
	logic [IDX_W-1:0]  win_mask;
	logic [IDX_W-1:0]  win_base;
	logic [HELD_W-1:0] held_base;
	logic [IDX_W-1:0]  win_nx;
	logic [HELD_W-1:0] held_nx;
	logic              kmer_full;
	base_code_t        bc;

	// Request side
	logic             accept;
	logic             is_read;
	logic [IDX_W-1:0] mem_rd_addr;
	logic             clear_busy;

	// Stage 1: RAM data returns, counter is modified and written back
	logic               v_s1;
	logic               read_s1;
	logic               inc_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               fwd_hit_s1;
	logic [COUNT_W-1:0] fwd_data_s1;
	logic [COUNT_W-1:0] ram_rd_data;
	logic [COUNT_W-1:0] old_cnt;
	logic [COUNT_W-1:0] new_cnt;
	logic               wr_en;
	kmer_rsp_t          rsp_s1;

	// Response queue
	kmer_rsp_t        q_data;
	logic             q_valid;
	logic [CNT_W-1:0] q_fill;

	// ---------------------------------------------------------------- configuration port
	assign pready      = 1'b1;
	assign cfg_sel_len = (paddr[APB_ADDR_W-1:2] == REG_KMER_LENGTH);
	assign cfg_wr      = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_len_q <= KMER_LEN_RST;
		end else if (cfg_wr && cfg_sel_len) begin
			kmer_len_q <= pwdata[KMER_LEN_W-1:0];
		end
	end

	assign prdata = (psel && cfg_sel_len) ? APB_DATA_W'(kmer_len_q) : '0;

	// ---------------------------------------------------------------- effective k and mask
	always_comb begin
		if (kmer_len_q == '0) begin
			k_eff = HELD_W'(1);
		end else if (32'(kmer_len_q) > MAX_K) begin
			k_eff = HELD_W'(MAX_K);
		end else begin
			k_eff = HELD_W'(kmer_len_q);
		end
	end

	// Keep the low 2k bits of the window.
	always_comb begin
		for (int i = 0; i < IDX_W; i++) begin
			win_mask[i] = (32'(i) < 2 * 32'(k_eff));
		end
	end

	// ---------------------------------------------------------------- window update
	assign bc        = decode_base(req.base_char);
	assign win_base  = req.seq_start ? '0 : win_q;
	assign held_base = req.seq_start ? '0 : held_q;

	always_comb begin
		if (!bc.ok) begin
			win_nx    = '0;
			held_nx   = '0;
			kmer_full = 1'b0;
		end else begin
			win_nx    = ((win_base << 2) | IDX_W'(bc.code)) & win_mask;
			held_nx   = (held_base < k_eff) ? held_base + 1'b1 : held_base;
			kmer_full = (held_nx >= k_eff);
		end
	end

	// Hold new requests while the table is swept or the queue could overfill.
	assign req.ready = !clear_busy && ((32'(q_fill) + 32'(v_s1)) < RSP_FIFO_DEPTH);
	assign accept    = req.valid && req.ready;
	assign is_read   = (req.req_type == REQ_READ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			held_q <= '0;
		end else if (accept && !is_read) begin
			win_q  <= win_nx;
			held_q <= held_nx;
		end
	end

	// Reads look up the masked query index, adds the freshly shifted window.
	assign mem_rd_addr = is_read ? IDX_W'(req.query_index) : win_nx;

	// ---------------------------------------------------------------- counter RAM
	kmer_sc_count_ram #(
		.IDX_W (IDX_W)
	) u_count_ram (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (accept),
		.rd_addr    (mem_rd_addr),
		.rd_data    (ram_rd_data),
		.wr_en      (wr_en),
		.wr_addr    (idx_s1),
		.wr_data    (new_cnt),
		.clear_busy (clear_busy)
	);

	// ---------------------------------------------------------------- stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	// The RAM reads old data when the word ahead writes the same counter in the
	// same cycle, so capture that write and use it instead.
	always_ff @(posedge clk) begin
		if (accept) begin
			read_s1     <= is_read;
			inc_s1      <= !is_read && kmer_full;
			idx_s1      <= mem_rd_addr;
			fwd_hit_s1  <= wr_en && (idx_s1 == mem_rd_addr);
			fwd_data_s1 <= new_cnt;
		end
	end

	assign old_cnt = fwd_hit_s1 ? fwd_data_s1 : ram_rd_data;
	assign new_cnt = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + 1'b1;
	assign wr_en   = v_s1 && inc_s1;

	always_comb begin
		rsp_s1 = '0;
		if (read_s1) begin
			rsp_s1.kmer_valid = 1'b1;
			rsp_s1.kmer_index = IDX_PORT_W'(idx_s1);
			rsp_s1.kmer_count = old_cnt;
		end else if (inc_s1) begin
			rsp_s1.kmer_valid = 1'b1;
			rsp_s1.kmer_index = IDX_PORT_W'(idx_s1);
			rsp_s1.kmer_count = new_cnt;
		end
	end

	// ---------------------------------------------------------------- response queue
	kmer_sc_rsp_fifo u_rsp_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s1),
		.push_data (rsp_s1),
		.pop       (rsp.valid && rsp.ready),
		.out_valid (q_valid),
		.out_data  (q_data),
		.fill      (q_fill)
	);

	assign rsp.valid      = q_valid;
	assign rsp.kmer_valid = q_data.kmer_valid;
	assign rsp.kmer_index = q_data.kmer_index;
	assign rsp.kmer_count = q_data.kmer_count;

endmodule

FILE: design/kmer_sc_count_ram.sv
// Counter table: one read and one write port, registered read, read-first on collision.
// Sweeps zeros through every entry after reset. Depends on kmer_sc_pkg.
module kmer_sc_count_ram import kmer_sc_pkg::*; #(
	parameter int unsigned IDX_W = 2 * KMER_MAX_K_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [IDX_W-1:0]   rd_addr,
	output logic [COUNT_W-1:0] rd_data,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_addr,
	input  logic [COUNT_W-1:0] wr_data,
	output logic               clear_busy
);
	localparam int unsigned DEPTH = 1 << IDX_W;

	logic [COUNT_W-1:0] count_mem [DEPTH];
	logic [COUNT_W-1:0] rd_data_q;
	logic               clr_busy_q;
	logic [IDX_W-1:0]   clr_addr_q;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_wa;
	logic [COUNT_W-1:0] mem_wd;

	// Clearing sweep: one entry a cycle, then drop busy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (&clr_addr_q) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign mem_we = clr_busy_q | wr_en;
	assign mem_wa = clr_busy_q ? clr_addr_q : wr_addr;
	assign mem_wd = clr_busy_q ? '0 : wr_data;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= count_mem[rd_addr];
		end
		if (mem_we) begin
			count_mem[mem_wa] <= mem_wd;
		end
	end

	assign rd_data    = rd_data_q;
	assign clear_busy = clr_busy_q;

endmodule

FILE: design/kmer_sc_rsp_fifo.sv
// Small response queue that decouples the counter pipeline from the response channel.
// Depends on kmer_sc_pkg for the response word type and depth.
module kmer_sc_rsp_fifo import kmer_sc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  kmer_rsp_t push_data,
	input  logic      pop,
	output logic      out_valid,
	output kmer_rsp_t out_data,
	output logic [$clog2(RSP_FIFO_DEPTH+1)-1:0] fill
);
	localparam int unsigned PTR_W = $clog2(RSP_FIFO_DEPTH);
	localparam int unsigned CNT_W = $clog2(RSP_FIFO_DEPTH + 1);

	kmer_rsp_t        slot_q [RSP_FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	assign out_valid = (cnt_q != '0);
	assign out_data  = slot_q[rd_ptr_q];
	assign fill      = cnt_q;

endmodule

FILE: design/kmer_sc_checker.sv
// Port-level checks of the k-mer counter, bound to the top level.
// Depends on kmer_sc_pkg and kmer_saturating_counter_unit_defines.svh.
`include "kmer_saturating_counter_unit_defines.svh"

module kmer_sc_checker import kmer_sc_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_ready,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input logic                  rsp_kmer_valid,
	input logic [IDX_PORT_W-1:0] rsp_kmer_index,
	input logic [COUNT_W-1:0]    rsp_kmer_count
);
	// A stalled response word stays offered and unchanged.
	`KMER_SC_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
	`KMER_SC_ASSERT_NXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_kmer_index) && $stable(rsp_kmer_count) && $stable(rsp_kmer_valid))
	// An incomplete add reports all zero.
	`KMER_SC_ASSERT_IMP(a_empty_zero, rsp_valid && !rsp_kmer_valid, rsp_kmer_index == '0 && rsp_kmer_count == '0)
	// The table sweep holds off requests right after reset.
	`KMER_SC_ASSERT_IMP(a_sweep_after_reset, $rose(arst_n), !req_ready)
endmodule

bind kmer_saturating_counter_unit kmer_sc_checker u_kmer_sc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_kmer_valid (rsp.kmer_valid),
	.rsp_kmer_index (rsp.kmer_index),
	.rsp_kmer_count (rsp.kmer_count)
);
